// ----- sv/brm_pkg.sv -----
package brm_pkg;

    localparam int HIST_DEPTH = 32;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    localparam logic [15:0] INTERVAL_RESET = 16'd50;
    localparam logic [31:0] KILO           = 32'd1000;
    // ceil(2^38 / 1000): (x * KILO_RECIP) >> 38 equals x / 1000 for every 32-bit x.
    localparam logic [31:0] KILO_RECIP     = 32'd274877907;

    // One ring entry. The kilobit values are the rates divided by 1000, kept
    // beside the rates so that sums and window walks need no division.
    typedef struct packed {
        logic [31:0] video_bps;
        logic [31:0] total_bps;
        logic [31:0] timestamp;
        logic [31:0] video_kb;
        logic [31:0] total_kb;
    } t_entry;

endpackage

// ----- sv/brm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module brm_div
    import brm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!rem_sub[32]) begin
                    r_rem <= rem_sub[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/bitrate_meter_moving_average.sv -----
// A request with no ring entry inside the window skips the window divisions; for n entries
// inside it (n up to 32) the walk reads each entry, then runs two serial divisions.
// A request that closes an interval adds two rate divisions (none at zero elapsed
// time); a stalled result output holds the block in its last step.
// The block takes no new request until it is done with the last one.
// Reset is synchronous, active low; it clears counters, sums and ring valid bits.
module bitrate_meter_moving_average
    import brm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,      // sample_interval_ms
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] time_now_ms, [47:32] video_bytes, [63:48] sent_bytes, [95:64] window_ms
    input  logic [95:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] cur_video_bps, [63:32] cur_total_bps, [95:64] avg_video_bps,
    // [127:96] avg_total_bps, [159:128] win_video_bps, [191:160] win_total_bps
    output logic [191:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // sample_taken
);

    // The sequencer walks one request through sampling and the window walk.
    // All divisions by a variable share the single serial divider below.
    typedef enum logic [4:0] {
        ST_IDLE, ST_OLD_WAIT, ST_OLD, ST_DIV_VR, ST_KV_START,
        ST_DIV_TR, ST_KT_START, ST_WRITE, ST_AVG,
        ST_W_WAIT, ST_W_LIMIT, ST_W_CHECK, ST_DIV_WV, ST_DIV_WT, ST_LOAD
    } t_state;

    t_state            r_state;
    logic [15:0]       r_interval;
    logic [31:0]       r_vcnt;
    logic [31:0]       r_scnt;
    logic [31:0]       r_last;
    logic [HIST_AW-1:0] r_pos;
    logic [HIST_AW-1:0] r_addr;
    logic [31:0]       r_vsum;
    logic [31:0]       r_tsum;
    logic [31:0]       r_vavg;
    logic [31:0]       r_tavg;
    logic [31:0]       r_now;
    logic [31:0]       r_win;
    logic              r_taken;
    logic [31:0]       r_rv;
    logic [31:0]       r_rt;
    logic [31:0]       r_kbv;
    logic [31:0]       r_kbt;
    logic [31:0]       r_limit;
    logic              r_first;
    logic [CNT_W-1:0]  r_n;
    logic [31:0]       r_sv;
    logic [31:0]       r_st;
    logic [31:0]       r_wv;
    logic [31:0]       r_wt;
    logic [31:0]       r_cur_v;
    logic [31:0]       r_cur_t;

    // Ring memory with registered read; valid bits make unwritten entries read zero.
    t_entry            r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_valid;
    t_entry            r_rd;
    logic              r_rd_vld;
    t_entry            rd;

    logic              r_div_start;
    logic [31:0]       r_div_a;
    logic [31:0]       r_div_b;
    logic              div_done;
    logic [31:0]       div_q;

    logic              r_out_valid;
    logic [191:0]      r_out_data;
    logic              r_out_user;

    logic [31:0]       in_now;
    logic [15:0]       in_vb;
    logic [15:0]       in_sb;
    logic [31:0]       in_win;
    logic [31:0]       deadline;
    logic [31:0]       delta;
    logic [HIST_AW-1:0] pos_next;
    logic [HIST_AW-1:0] addr_prev;
    logic              in_acc;
    logic              out_free;

    // Division by 1000 as a multiplication by the scaled reciprocal.
    function automatic logic [31:0] kilo_of(input logic [31:0] value);
        logic [63:0] prod;
        prod = {32'd0, value} * {32'd0, KILO_RECIP};
        return {6'd0, prod[63:38]};
    endfunction

    assign in_now  = i_s_axis_tdata[31:0];
    assign in_vb   = i_s_axis_tdata[47:32];
    assign in_sb   = i_s_axis_tdata[63:48];
    assign in_win  = i_s_axis_tdata[95:64];
    assign deadline = r_last + {16'd0, r_interval};
    assign delta    = r_now - r_last;
    assign pos_next = (r_pos == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_pos + 1'b1;
    assign addr_prev = (r_addr == '0) ? HIST_AW'(HIST_DEPTH - 1) : r_addr - 1'b1;
    assign in_acc   = (r_state == ST_IDLE) && i_s_axis_tvalid;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign rd       = r_rd_vld ? r_rd : '0;

    brm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
        if (r_state == ST_WRITE) begin
            r_mem[r_addr] <= '{video_bps: r_rv, total_bps: r_rt, timestamp: r_now,
                               video_kb: r_kbv, total_kb: r_kbt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_interval  <= INTERVAL_RESET;
            r_vcnt      <= '0;
            r_scnt      <= '0;
            r_last      <= '0;
            r_pos       <= '0;
            r_addr      <= '0;
            r_vsum      <= '0;
            r_tsum      <= '0;
            r_vavg      <= '0;
            r_tavg      <= '0;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= r_valid[r_addr];
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_now  <= in_now;
                        r_win  <= in_win;
                        r_vcnt <= r_vcnt + {16'd0, in_vb};
                        r_scnt <= r_scnt + {16'd0, in_sb};
                        r_first <= 1'b1;
                        if (!(in_now < deadline)) begin
                            r_taken <= 1'b1;
                            r_addr  <= pos_next;
                            r_state <= ST_OLD_WAIT;
                        end else begin
                            r_taken <= 1'b0;
                            r_addr  <= r_pos;
                            r_state <= ST_W_WAIT;
                        end
                    end
                end
                ST_OLD_WAIT: begin
                    r_state <= ST_OLD;
                end
                ST_OLD: begin
                    // Retire the overwritten entry from the running sums.
                    r_vsum <= r_vsum - rd.video_kb;
                    r_tsum <= r_tsum - rd.total_kb;
                    if (delta != '0) begin
                        r_div_a     <= {r_vcnt[28:0], 3'b000};
                        r_div_b     <= delta;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_VR;
                    end else begin
                        r_rv    <= rd.video_bps;
                        r_rt    <= rd.total_bps;
                        r_kbv   <= rd.video_kb;
                        r_kbt   <= rd.total_kb;
                        r_state <= ST_WRITE;
                    end
                end
                ST_DIV_VR: begin
                    if (div_done) begin
                        r_rv    <= div_q * KILO;
                        r_state <= ST_KV_START;
                    end
                end
                ST_KV_START: begin
                    // The rate wraps at 32 bits, so its kilobit value is taken again.
                    r_kbv       <= kilo_of(r_rv);
                    r_div_a     <= {r_scnt[28:0], 3'b000};
                    r_div_b     <= delta;
                    r_div_start <= 1'b1;
                    r_state     <= ST_DIV_TR;
                end
                ST_DIV_TR: begin
                    if (div_done) begin
                        r_rt    <= div_q * KILO;
                        r_state <= ST_KT_START;
                    end
                end
                ST_KT_START: begin
                    r_kbt   <= kilo_of(r_rt);
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_valid[r_addr] <= 1'b1;
                    r_vsum  <= r_vsum + r_kbv;
                    r_tsum  <= r_tsum + r_kbt;
                    r_pos   <= r_addr;
                    r_last  <= r_now;
                    r_vcnt  <= '0;
                    r_scnt  <= '0;
                    r_state <= ST_AVG;
                end
                ST_AVG: begin
                    r_vavg  <= (r_vsum / HIST_DEPTH) * KILO;
                    r_tavg  <= (r_tsum / HIST_DEPTH) * KILO;
                    r_state <= ST_W_WAIT;
                end
                ST_W_WAIT: begin
                    r_state <= r_first ? ST_W_LIMIT : ST_W_CHECK;
                end
                ST_W_LIMIT: begin
                    // Newest entry: fixes the window limit and the current rates.
                    r_first <= 1'b0;
                    r_limit <= rd.timestamp - r_win;
                    r_cur_v <= rd.video_bps;
                    r_cur_t <= rd.total_bps;
                    r_n     <= '0;
                    r_sv    <= '0;
                    r_st    <= '0;
                    r_state <= ST_W_CHECK;
                end
                ST_W_CHECK: begin
                    if ((r_n < CNT_W'(HIST_DEPTH)) && (rd.timestamp >= r_limit)) begin
                        r_sv    <= r_sv + rd.video_kb;
                        r_st    <= r_st + rd.total_kb;
                        r_n     <= r_n + 1'b1;
                        r_addr  <= addr_prev;
                        r_state <= ST_W_WAIT;
                    end else if (r_n == '0) begin
                        r_wv    <= '0;
                        r_wt    <= '0;
                        r_state <= ST_LOAD;
                    end else begin
                        r_div_a     <= r_sv;
                        r_div_b     <= {{(32 - CNT_W){1'b0}}, r_n};
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_WV;
                    end
                end
                ST_DIV_WV: begin
                    if (div_done) begin
                        r_wv        <= div_q * KILO;
                        r_div_a     <= r_st;
                        r_div_b     <= {{(32 - CNT_W){1'b0}}, r_n};
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_WT;
                    end
                end
                ST_DIV_WT: begin
                    if (div_done) begin
                        r_wt    <= div_q * KILO;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // Wait until the output register is free, then post the result.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_wt, r_wv, r_tavg, r_vavg, r_cur_t, r_cur_v};
                        r_out_user  <= r_taken;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
